// File: hw/rtl/lbps_pkg.sv
// lbps_pkg: shared types and constants for the linear bias parent selector.
// Used by lbps_ctrl, lbps_dp, lbps_out and linear_bias_parent_select.
// No dependencies.
package lbps_pkg;

	localparam int RAND_W    = 16;
	localparam int BIAS_W    = 16;
	localparam int SIZE_W    = 11;
	localparam int IDX_W     = 10;
	localparam int FRAC_BITS = 16;
	localparam int TDATA_W   = 16;

	// Q14 bias limits and maximum pool size
	localparam logic [BIAS_W-1:0] ONE_Q14 = 16'd16384;
	localparam logic [BIAS_W-1:0] TWO_Q14 = 16'd32768;
	localparam logic [SIZE_W-1:0] MAX_POOL = 11'd1024;

	// datapath widths
	localparam int MUL_A_W = 24;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int LEAD_W  = 31;
	localparam int ACC_W   = 48;
	localparam int ROOT_W  = 24;
	localparam int REM_W   = 35;
	localparam int QUO_W   = 11;
	localparam int D_W     = 15;

	// iteration counts
	localparam int SQRT_STEPS = 24;
	localparam int DIV_STEPS  = 11;
	localparam int CNT_W      = 5;

	// register indexes
	localparam logic REG_BIAS = 1'b0;
	localparam logic REG_POOL = 1'b1;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL_BSQ,
		OP_MUL_DR,
		OP_DISC,
		OP_SQRT,
		OP_NUM,
		OP_MUL_SZ,
		OP_DIV_INIT,
		OP_DIV
	} op_t;

	typedef struct packed {
		op_t  op;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic lin;
		logic out_free;
	} sts_t;

endpackage

// File: hw/rtl/lbps_ctrl.sv
// lbps_ctrl: sequencer for one draw (multiplies, root loop, divide loop, emit).
// Depends on lbps_pkg.
module lbps_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lbps_pkg::sts_t sts,
	output lbps_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MBSQ,
		ST_MDR,
		ST_DISC,
		ST_SQRT,
		ST_NUM,
		ST_MSZ,
		ST_DINIT,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                       state_q;
	logic [lbps_pkg::CNT_W-1:0]   cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd.op   = lbps_pkg::OP_NONE;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE:  cmd.op = in_valid ? lbps_pkg::OP_LOAD : lbps_pkg::OP_NONE;
			ST_MBSQ:  cmd.op = lbps_pkg::OP_MUL_BSQ;
			ST_MDR:   cmd.op = lbps_pkg::OP_MUL_DR;
			ST_DISC:  cmd.op = lbps_pkg::OP_DISC;
			ST_SQRT:  cmd.op = lbps_pkg::OP_SQRT;
			ST_NUM:   cmd.op = lbps_pkg::OP_NUM;
			ST_MSZ:   cmd.op = lbps_pkg::OP_MUL_SZ;
			ST_DINIT: cmd.op = lbps_pkg::OP_DIV_INIT;
			ST_DIV:   cmd.op = lbps_pkg::OP_DIV;
			ST_DONE:  cmd.emit = sts.out_free;
			default:  cmd.op = lbps_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= sts.lin ? ST_MSZ : ST_MBSQ;
					end
				end
				ST_MBSQ: state_q <= ST_MDR;
				ST_MDR:  state_q <= ST_DISC;
				ST_DISC: begin
					state_q <= ST_SQRT;
					cnt_q   <= '0;
				end
				ST_SQRT: begin
					if (cnt_q == lbps_pkg::CNT_W'(lbps_pkg::SQRT_STEPS - 1)) begin
						state_q <= ST_NUM;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_NUM:  state_q <= ST_MSZ;
				ST_MSZ:  state_q <= sts.lin ? ST_DONE : ST_DINIT;
				ST_DINIT: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					if (cnt_q == lbps_pkg::CNT_W'(lbps_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// root loop counter never runs past its iteration count
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (cnt_q < lbps_pkg::CNT_W'(lbps_pkg::SQRT_STEPS)))
		else $error("root loop counter out of range");
	// an emit ends the draw and returns the sequencer to idle
	a_emit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (state_q == ST_IDLE))
		else $error("emit did not end the draw");
`endif

endmodule

// File: hw/rtl/lbps_dp.sv
// lbps_dp: arithmetic for one draw: shared multiplier, bit-pair square root,
// restoring divider and index clamp. Depends on lbps_pkg.
module lbps_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lbps_pkg::cmd_t                cmd,
	input  logic [lbps_pkg::RAND_W-1:0]   rand_fraction,
	input  logic [lbps_pkg::BIAS_W-1:0]   bias,      // saturated to 2.0
	input  logic [lbps_pkg::SIZE_W-1:0]   size,      // 1..MAX_POOL
	output logic                          lin,
	output logic [lbps_pkg::IDX_W-1:0]    parent_index
);

	logic [lbps_pkg::RAND_W-1:0]  r_q;
	logic [lbps_pkg::PROD_W-1:0]  prod_q;
	logic [lbps_pkg::LEAD_W-1:0]  lead_q;
	logic [lbps_pkg::ACC_W-1:0]   acc_q;
	logic [lbps_pkg::ACC_W-1:0]   res_q;
	logic [lbps_pkg::ACC_W-1:0]   bit_q;
	logic [lbps_pkg::MUL_A_W-1:0] num_q;
	logic [lbps_pkg::REM_W-1:0]   rem_q;
	logic [lbps_pkg::REM_W-1:0]   dsh_q;
	logic [lbps_pkg::QUO_W-1:0]   quo_q;

	logic [lbps_pkg::D_W-1:0]     d;
	logic [lbps_pkg::MUL_A_W-1:0] mul_a;
	logic [lbps_pkg::MUL_B_W-1:0] mul_b;
	logic [lbps_pkg::LEAD_W-1:0]  dr;
	logic [lbps_pkg::ACC_W-1:0]   trial;
	logic [lbps_pkg::MUL_A_W-1:0] top;
	logic [lbps_pkg::MUL_A_W-1:0] root;
	logic [lbps_pkg::QUO_W-1:0]   cand;
	logic [lbps_pkg::SIZE_W-1:0]  size_m1;

	assign lin     = (bias <= lbps_pkg::ONE_Q14);
	assign d       = lbps_pkg::D_W'(bias - lbps_pkg::ONE_Q14);
	assign dr      = prod_q[lbps_pkg::LEAD_W-1:0];
	assign trial   = res_q + bit_q;
	assign top     = {bias, 8'b0};
	assign root    = res_q[lbps_pkg::ROOT_W-1:0];
	assign size_m1 = size - 1'b1;

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			lbps_pkg::OP_MUL_BSQ: begin
				mul_a = lbps_pkg::MUL_A_W'(bias);
				mul_b = bias;
			end
			lbps_pkg::OP_MUL_DR: begin
				mul_a = lbps_pkg::MUL_A_W'(d);
				mul_b = r_q;
			end
			lbps_pkg::OP_MUL_SZ: begin
				mul_a = lin ? lbps_pkg::MUL_A_W'(r_q) : num_q;
				mul_b = lbps_pkg::MUL_B_W'(size);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// index: top bits of r*size, or the quotient; clamp to size-1
	assign cand = lin ? prod_q[lbps_pkg::FRAC_BITS +: lbps_pkg::QUO_W] : quo_q;
	assign parent_index = (cand > size_m1) ? lbps_pkg::IDX_W'(size_m1)
	                                       : lbps_pkg::IDX_W'(cand);

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			lbps_pkg::OP_LOAD: r_q <= rand_fraction;
			lbps_pkg::OP_MUL_BSQ: prod_q <= mul_a * mul_b;
			lbps_pkg::OP_MUL_DR: begin
				lead_q <= prod_q[lbps_pkg::LEAD_W-1:0];
				prod_q <= mul_a * mul_b;
			end
			lbps_pkg::OP_DISC: begin
				// (b*b - d*r) << 16, floored at zero
				acc_q <= (lead_q > dr) ? {1'b0, lead_q - dr, 16'b0} : '0;
				res_q <= '0;
				bit_q <= lbps_pkg::ACC_W'(1) << (lbps_pkg::ACC_W - 2);
			end
			lbps_pkg::OP_SQRT: begin
				if (acc_q >= trial) begin
					acc_q <= acc_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			lbps_pkg::OP_NUM: num_q <= (top > root) ? top - root : '0;
			lbps_pkg::OP_MUL_SZ: prod_q <= mul_a * mul_b;
			lbps_pkg::OP_DIV_INIT: begin
				// quotient never exceeds size, so 11 bits cover it
				rem_q <= prod_q[lbps_pkg::REM_W-1:0];
				dsh_q <= {1'b0, d, 19'b0};
				quo_q <= '0;
			end
			lbps_pkg::OP_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[lbps_pkg::QUO_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[lbps_pkg::QUO_W-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	a_root_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lbps_pkg::OP_SQRT) |-> $onehot(bit_q))
		else $error("root trial bit lost");
	a_div_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lbps_pkg::OP_DIV) |-> (rem_q < {dsh_q, 1'b0}))
		else $error("quotient overflows divider");
`endif

endmodule

// File: hw/rtl/lbps_out.sv
// lbps_out: pairing of draws into parents and the output register.
// Depends on lbps_pkg.
module lbps_out (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        emit,
	input  logic [lbps_pkg::IDX_W-1:0]  parent_index,
	input  logic                        size_gt1,
	output logic                        out_free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lbps_pkg::IDX_W-1:0]  idx_out,
	output logic                        m_tlast
);

	logic                       holding_q;
	logic [lbps_pkg::IDX_W-1:0] first_q;
	logic                       redraw;

	assign out_free = !m_tvalid || m_tready;
	assign redraw   = holding_q && size_gt1 && (parent_index == first_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid  <= 1'b0;
			holding_q <= 1'b0;
			first_q   <= '0;
		end else begin
			if (emit && !redraw) begin
				m_tvalid  <= 1'b1;
				holding_q <= !holding_q;
				if (!holding_q) begin
					first_q <= parent_index;
				end
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && !redraw) begin
			idx_out <= parent_index;
			m_tlast <= holding_q;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!m_tvalid || m_tready))
		else $error("result written over a waiting word");
	a_single_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !size_gt1) |=> m_tvalid)
		else $error("draw dropped with a single-entry pool");
`endif

endmodule

// File: hw/rtl/linear_bias_parent_select.sv
// linear_bias_parent_select: top level; configuration registers and wiring.
// Depends on lbps_pkg, lbps_ctrl, lbps_dp, lbps_out.
//
// Usage:
//   Slave stream: each word carries one 16-bit uniform random fraction.
//   Master stream: each word carries a selected rank index; tlast marks the
//   second parent, which closes the pair. A second draw equal to the held
//   first parent produces no word while the pool holds more than one entry.
//   Config port: cfg_we writes cfg_data to register cfg_index
//   (0 = bias in Q14, 1 = pool size); write only while the block is idle.
// Timing:
//   One draw at a time. With bias at or below 1.0 a draw runs accept,
//   multiply by pool size and emit. Above 1.0 it runs accept, two
//   multiplies, discriminant, 24 steps of the bit-pair square root,
//   numerator, one multiply, divider load, 11 steps of the restoring
//   divider and emit. s_tready is high only between draws. A result waits
//   in the output register while the next draw is taken; a stalled receiver
//   holds the sequencer in its last step once a second result is ready.
// Reset: arst_n clears the sequencer, the open pair and the output valid, and
//   loads bias 1.5 and pool size 1024.
module linear_bias_parent_select (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [15:0] rand_fraction
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,    // [9:0] parent_index, [15:10] zero
	output logic        m_tlast,    // is_second
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	logic [lbps_pkg::BIAS_W-1:0] bias_q;
	logic [lbps_pkg::SIZE_W-1:0] pool_q;
	logic [lbps_pkg::BIAS_W-1:0] bias_sat;
	logic [lbps_pkg::SIZE_W-1:0] size_eff;
	logic [lbps_pkg::IDX_W-1:0]  pick;
	logic [lbps_pkg::IDX_W-1:0]  idx_out;
	lbps_pkg::cmd_t              cmd;
	lbps_pkg::sts_t              sts;
	logic                        lin;
	logic                        out_free;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= 16'd24576;
			pool_q <= lbps_pkg::MAX_POOL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lbps_pkg::REG_BIAS: bias_q <= cfg_data;
				lbps_pkg::REG_POOL: pool_q <= cfg_data[lbps_pkg::SIZE_W-1:0];
			endcase
		end
	end

	// bias caps at 2.0; pool size of zero acts as one, above max caps
	assign bias_sat = (bias_q > lbps_pkg::TWO_Q14) ? lbps_pkg::TWO_Q14 : bias_q;
	always_comb begin
		if (pool_q == '0) begin
			size_eff = lbps_pkg::SIZE_W'(1);
		end else if (pool_q > lbps_pkg::MAX_POOL) begin
			size_eff = lbps_pkg::MAX_POOL;
		end else begin
			size_eff = pool_q;
		end
	end

	assign sts.lin      = lin;
	assign sts.out_free = out_free;

	lbps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lbps_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.rand_fraction (s_tdata),
		.bias          (bias_sat),
		.size          (size_eff),
		.lin           (lin),
		.parent_index  (pick)
	);

	lbps_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.emit         (cmd.emit),
		.parent_index (pick),
		.size_gt1     (size_eff > lbps_pkg::SIZE_W'(1)),
		.out_free     (out_free),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.idx_out      (idx_out),
		.m_tlast      (m_tlast)
	);

	assign m_tdata = {{(lbps_pkg::TDATA_W - lbps_pkg::IDX_W){1'b0}}, idx_out};

endmodule
